// ===== rtl/adts_pkg.sv =====
// ----------------------------------------------------------------------------
// adts_pkg
// Shared widths, constants, register indexes and types of the torque split.
// ----------------------------------------------------------------------------
package adts_pkg;

  // Request and result field widths
  localparam int unsigned ANGLE_W  = 15;
  localparam int unsigned POWER_W  = 11;
  localparam int unsigned SPEED_W  = 16;
  localparam int unsigned TORQUE_W = 16;

  // Register widths
  localparam int unsigned HTW_W = 16;
  localparam int unsigned PF_W  = 24;
  localparam int unsigned CAP_W = 15;
  localparam int unsigned EPS_W = 8;

  // Angle saturation, 0.01 degree
  localparam int unsigned ANGLE_SAT   = 4500;
  localparam int unsigned ANGLE_SAT_W = 13;

  // Q16 quantities
  localparam int unsigned TAN_W   = 17;
  localparam int unsigned DMAG_W  = 16;
  localparam int unsigned COEF_W  = 17;
  localparam logic [COEF_W-1:0] Q16_ONE = 17'd65536;

  // Q30 constants for the tangent table
  localparam logic [63:0] Q30_ONE = 64'd1073741824;
  localparam logic [63:0] PI_Q30  = 64'd3373259426;

  // Datapath widths after the tangent stage
  localparam int unsigned PROD_W = 34;  // speed times coefficient
  localparam int unsigned D_W    = 36;  // weighted speed sum, signed
  localparam int unsigned NUM_W  = 35;  // power factor times power
  localparam int unsigned TNUM_W = 53;  // share numerator
  localparam int unsigned TDEN_W = 42;  // share denominator
  localparam int unsigned CNUM_W = 32;  // capped share numerator
  localparam int unsigned QUO_W  = 15;  // quotient bits

  // Register reset values
  localparam logic [HTW_W-1:0] HTW_RST = 16'd23255;
  localparam logic [PF_W-1:0]  PF_RST  = 24'd2444544;
  localparam logic [CAP_W-1:0] CAP_RST = 15'd2100;
  localparam logic [EPS_W-1:0] EPS_RST = 8'd1;

  typedef enum logic [1:0] {
    REG_HTW = 2'd0,
    REG_PF  = 2'd1,
    REG_CAP = 2'd2,
    REG_EPS = 2'd3
  } reg_idx_e;

  typedef struct packed {
    logic [PF_W-1:0]  power_factor;
    logic [CAP_W-1:0] torque_cap;
    logic [EPS_W-1:0] speed_epsilon;
  } cfg_t;

  typedef struct packed {
    logic [POWER_W-1:0] power;
    logic [SPEED_W-1:0] left_speed;
    logic [SPEED_W-1:0] right_speed;
  } req_side_t;

endpackage

// ===== rtl/adts_tan.sv =====
// ----------------------------------------------------------------------------
// adts_tan
// Tangent lookup with interpolation, delta and the two wheel coefficients.
// ----------------------------------------------------------------------------
module adts_tan #(
  parameter int unsigned TAN_TABLE_ENTRIES = 256
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                en_i,
  input  logic                                valid_i,
  input  logic [adts_pkg::ANGLE_W-1:0]        angle_i,
  input  adts_pkg::req_side_t                 side_i,
  input  logic [adts_pkg::HTW_W-1:0]          htw_i,
  output logic                                valid_o,
  output logic [adts_pkg::COEF_W-1:0]         cl_o,
  output logic [adts_pkg::COEF_W-1:0]         cr_o,
  output adts_pkg::req_side_t                 side_o
);

  localparam int unsigned N      = TAN_TABLE_ENTRIES;
  localparam int unsigned IDX_W  = $clog2(N + 1);
  localparam int unsigned POS_W  = $clog2(adts_pkg::ANGLE_SAT * N + 1);
  localparam int unsigned SH1    = POS_W + adts_pkg::ANGLE_SAT_W;
  localparam int unsigned M1_W   = POS_W + 1;
  localparam logic [63:0] M1     = ((64'd1 << SH1) + 64'(adts_pkg::ANGLE_SAT) - 64'd1)
                                   / 64'(adts_pkg::ANGLE_SAT);
  localparam int unsigned P_W    = 31;
  localparam int unsigned SH2    = P_W + adts_pkg::ANGLE_SAT_W;
  localparam logic [63:0] M2     = ((64'd1 << SH2) + 64'(adts_pkg::ANGLE_SAT) - 64'd1)
                                   / 64'(adts_pkg::ANGLE_SAT);
  localparam int unsigned TW     = adts_pkg::TAN_W;
  localparam int unsigned FW     = adts_pkg::ANGLE_SAT_W;
  localparam int unsigned DP_W   = TW + adts_pkg::HTW_W;

  // Constant tangent table, Q16, computed from a Q30 series at elaboration
  logic [TW-1:0] tan_tab [N+1];

  for (genvar gi = 0; gi <= N; gi++) begin : g_tab
    localparam logic [63:0] X   = (64'(gi) * adts_pkg::PI_Q30) / (64'd4 * 64'(N));
    localparam logic [63:0] TS1 = ((((X   * X) >> 30) * X) >> 30) / 64'd6;
    localparam logic [63:0] TS2 = ((((TS1 * X) >> 30) * X) >> 30) / 64'd20;
    localparam logic [63:0] TS3 = ((((TS2 * X) >> 30) * X) >> 30) / 64'd42;
    localparam logic [63:0] TS4 = ((((TS3 * X) >> 30) * X) >> 30) / 64'd72;
    localparam logic [63:0] TS5 = ((((TS4 * X) >> 30) * X) >> 30) / 64'd110;
    localparam logic [63:0] TS6 = ((((TS5 * X) >> 30) * X) >> 30) / 64'd156;
    localparam logic [63:0] TC1 = ((((adts_pkg::Q30_ONE * X) >> 30) * X) >> 30) / 64'd2;
    localparam logic [63:0] TC2 = ((((TC1 * X) >> 30) * X) >> 30) / 64'd12;
    localparam logic [63:0] TC3 = ((((TC2 * X) >> 30) * X) >> 30) / 64'd30;
    localparam logic [63:0] TC4 = ((((TC3 * X) >> 30) * X) >> 30) / 64'd56;
    localparam logic [63:0] TC5 = ((((TC4 * X) >> 30) * X) >> 30) / 64'd90;
    localparam logic [63:0] TC6 = ((((TC5 * X) >> 30) * X) >> 30) / 64'd132;
    localparam logic [63:0] SS  = X - TS1 + TS2 - TS3 + TS4 - TS5 + TS6;
    localparam logic [63:0] CC  = adts_pkg::Q30_ONE - TC1 + TC2 - TC3 + TC4 - TC5 + TC6;
    localparam logic [63:0] TV  = ((SS << 16) + CC / 64'd2) / CC;
    assign tan_tab[gi] = TV[TW-1:0];
  end

  // Stage valid bits
  logic [7:1] v_q;
  logic [7:1] v_d;

  // Sideband and sign travel along every stage
  adts_pkg::req_side_t side_q [7:1];
  logic [7:1]          neg_q;

  // Stage payloads
  logic [POS_W-1:0]            pos1_q, pos1_d, pos2_q;
  logic [IDX_W-1:0]            idx2_q, idx2_d;
  logic [FW-1:0]               frac3_q, frac3_d;
  logic [TW-1:0]               a3_q, a3_d, diff3_q, diff3_d, a4_q, a5_q;
  logic [P_W-1:0]              p4_q, p4_d;
  logic [TW-1:0]               qi5_q, qi5_d;
  logic [DP_W-1:0]             dp6_q, dp6_d;
  logic [adts_pkg::COEF_W-1:0] cl7_q, cl7_d, cr7_q, cr7_d;

  // Combinational helpers
  logic [adts_pkg::ANGLE_W-1:0]     abs_ang;
  logic [adts_pkg::ANGLE_SAT_W-1:0] mag;
  logic [POS_W+M1_W-1:0]            prod1;
  logic [IDX_W-1:0]                 idx_hi;
  logic [63:0]                      prod2;
  logic [TW-1:0]                    t6;
  logic [adts_pkg::DMAG_W-1:0]      dmag;

  // Stage 1: magnitude, saturate, scale to table positions
  assign abs_ang = angle_i[adts_pkg::ANGLE_W-1] ? (~angle_i + 1'b1) : angle_i;
  assign mag     = (abs_ang > adts_pkg::ANGLE_W'(adts_pkg::ANGLE_SAT)) ?
                   adts_pkg::ANGLE_SAT_W'(adts_pkg::ANGLE_SAT) : abs_ang[FW-1:0];
  assign pos1_d  = POS_W'(mag) * POS_W'(N);

  // Stage 2: table index by reciprocal multiply
  assign prod1  = (POS_W+M1_W)'(pos1_q) * (POS_W+M1_W)'(M1[M1_W-1:0]);
  assign idx2_d = IDX_W'(prod1 >> SH1);

  // Stage 3: remainder and table reads
  assign idx_hi  = (idx2_q == IDX_W'(N)) ? idx2_q : idx2_q + 1'b1;
  assign frac3_d = FW'(pos2_q - POS_W'(idx2_q) * POS_W'(adts_pkg::ANGLE_SAT));
  assign a3_d    = tan_tab[idx2_q];
  assign diff3_d = tan_tab[idx_hi] - tan_tab[idx2_q];

  // Stage 4: interpolation product, rounded
  assign p4_d = P_W'(diff3_q) * P_W'(frac3_q) + P_W'(adts_pkg::ANGLE_SAT / 2);

  // Stage 5: divide by the angle step through the reciprocal
  assign prod2 = 64'(p4_q) * 64'(M2[31:0]);
  assign qi5_d = TW'(prod2 >> SH2);

  // Stage 6: tangent, times the track ratio
  assign t6    = a5_q + qi5_q;
  assign dp6_d = DP_W'(t6) * DP_W'(htw_i);

  // Stage 7: delta and the coefficients
  assign dmag  = adts_pkg::DMAG_W'((dp6_q + DP_W'(32768)) >> 16);
  assign cl7_d = neg_q[6] ? adts_pkg::Q16_ONE - adts_pkg::COEF_W'(dmag)
                          : adts_pkg::Q16_ONE + adts_pkg::COEF_W'(dmag);
  assign cr7_d = neg_q[6] ? adts_pkg::Q16_ONE + adts_pkg::COEF_W'(dmag)
                          : adts_pkg::Q16_ONE - adts_pkg::COEF_W'(dmag);

  assign v_d = {v_q[6:1], valid_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en_i) begin
      v_q <= v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      side_q[1] <= side_i;
      neg_q[1]  <= angle_i[adts_pkg::ANGLE_W-1];
      for (int k = 2; k <= 7; k++) begin
        side_q[k] <= side_q[k-1];
        neg_q[k]  <= neg_q[k-1];
      end
      pos1_q  <= pos1_d;
      pos2_q  <= pos1_q;
      idx2_q  <= idx2_d;
      frac3_q <= frac3_d;
      a3_q    <= a3_d;
      diff3_q <= diff3_d;
      p4_q    <= p4_d;
      a4_q    <= a3_q;
      qi5_q   <= qi5_d;
      a5_q    <= a4_q;
      dp6_q   <= dp6_d;
      cl7_q   <= cl7_d;
      cr7_q   <= cr7_d;
    end
  end

  assign valid_o = v_q[7];
  assign cl_o    = cl7_q;
  assign cr_o    = cr7_q;
  assign side_o  = side_q[7];

endmodule

// ===== rtl/adts_den.sv =====
// ----------------------------------------------------------------------------
// adts_den
// Weighted speed sum, torque numerators and the capped-share operands.
// ----------------------------------------------------------------------------
module adts_den (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           en_i,
  input  logic                           valid_i,
  input  logic [adts_pkg::COEF_W-1:0]    cl_i,
  input  logic [adts_pkg::COEF_W-1:0]    cr_i,
  input  adts_pkg::req_side_t            side_i,
  input  adts_pkg::cfg_t                 cfg_i,
  output logic                           valid_o,
  output logic                           bad_o,
  output logic [adts_pkg::TNUM_W-1:0]    numl_o,
  output logic [adts_pkg::TNUM_W-1:0]    numr_o,
  output logic [adts_pkg::TDEN_W-1:0]    den_o,
  output logic [adts_pkg::CNUM_W-1:0]    capl_o,
  output logic [adts_pkg::CNUM_W-1:0]    capr_o,
  output logic [adts_pkg::COEF_W-1:0]    cmax_o
);

  localparam int unsigned CW = adts_pkg::COEF_W;
  localparam int unsigned PW = adts_pkg::PROD_W;
  localparam int unsigned DW = adts_pkg::D_W;
  localparam int unsigned NW = adts_pkg::NUM_W;
  localparam int unsigned TW = adts_pkg::TNUM_W;
  localparam int unsigned KW = adts_pkg::CNUM_W;

  logic [3:1] v_q;

  // Stage 1: speed products and power numerator
  logic signed [PW-1:0] pl1_q, pl1_d, pr1_q, pr1_d;
  logic [NW-1:0]        num1_q, num1_d, num2_q;
  logic [CW-1:0]        cl1_q, cr1_q, cl2_q, cr2_q;

  // Stage 2: weighted sum
  logic signed [DW-1:0] d2_q, d2_d;
  logic                 bad2_q, bad2_d, bad3_q;

  // Stage 3: numerators and denominators
  logic [TW-1:0]                  numl3_q, numl3_d, numr3_q, numr3_d;
  logic [adts_pkg::TDEN_W-1:0]    den3_q, den3_d;
  logic [KW-1:0]                  capl3_q, capl3_d, capr3_q, capr3_d;
  logic [CW-1:0]                  cmax3_q, cmax3_d;

  assign pl1_d  = PW'($signed(side_i.left_speed))  * $signed({1'b0, cl_i});
  assign pr1_d  = PW'($signed(side_i.right_speed)) * $signed({1'b0, cr_i});
  assign num1_d = NW'(cfg_i.power_factor) * NW'(side_i.power);

  assign d2_d   = DW'(pl1_q) + DW'(pr1_q)
                + $signed({12'b0, cfg_i.speed_epsilon, 16'b0});
  assign bad2_d = d2_d[DW-1] || (d2_d == '0);

  // d stays below 2^34 when positive
  assign den3_d  = {d2_q[33:0], 8'b0};
  assign numl3_d = TW'(num2_q) * TW'(cl2_q) + TW'({d2_q[33:0], 7'b0});
  assign numr3_d = TW'(num2_q) * TW'(cr2_q) + TW'({d2_q[33:0], 7'b0});
  assign cmax3_d = (cl2_q > cr2_q) ? cl2_q : cr2_q;
  assign capl3_d = KW'(cfg_i.torque_cap) * KW'(cl2_q) + KW'(cmax3_d >> 1);
  assign capr3_d = KW'(cfg_i.torque_cap) * KW'(cr2_q) + KW'(cmax3_d >> 1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en_i) begin
      v_q <= {v_q[2:1], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pl1_q   <= pl1_d;
      pr1_q   <= pr1_d;
      num1_q  <= num1_d;
      cl1_q   <= cl_i;
      cr1_q   <= cr_i;
      d2_q    <= d2_d;
      bad2_q  <= bad2_d;
      num2_q  <= num1_q;
      cl2_q   <= cl1_q;
      cr2_q   <= cr1_q;
      bad3_q  <= bad2_q;
      numl3_q <= numl3_d;
      numr3_q <= numr3_d;
      den3_q  <= den3_d;
      capl3_q <= capl3_d;
      capr3_q <= capr3_d;
      cmax3_q <= cmax3_d;
    end
  end

  assign valid_o = v_q[3];
  assign bad_o   = bad3_q;
  assign numl_o  = numl3_q;
  assign numr_o  = numr3_q;
  assign den_o   = den3_q;
  assign capl_o  = capl3_q;
  assign capr_o  = capr3_q;
  assign cmax_o  = cmax3_q;

endmodule

// ===== rtl/adts_div.sv =====
// ----------------------------------------------------------------------------
// adts_div
// Pipelined restoring divider: two numerators over one shared denominator,
// one quotient bit per stage.
// ----------------------------------------------------------------------------
module adts_div #(
  parameter int unsigned NUM_W  = 53,
  parameter int unsigned DEN_W  = 42,
  parameter int unsigned QUO_W  = 15,
  parameter int unsigned SIDE_W = 1
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic              valid_i,
  input  logic [NUM_W-1:0]  num_a_i,
  input  logic [NUM_W-1:0]  num_b_i,
  input  logic [DEN_W-1:0]  den_i,
  input  logic [SIDE_W-1:0] side_i,
  output logic              valid_o,
  output logic              ovf_o,
  output logic [QUO_W-1:0]  quo_a_o,
  output logic [QUO_W-1:0]  quo_b_o,
  output logic [SIDE_W-1:0] side_o
);

  localparam int unsigned RW = (NUM_W > DEN_W + QUO_W) ? NUM_W : DEN_W + QUO_W;

  logic [QUO_W:0]    v_q;
  logic [RW-1:0]     rem_a_q [QUO_W+1];
  logic [RW-1:0]     rem_b_q [QUO_W+1];
  logic [QUO_W-1:0]  qa_q    [QUO_W+1];
  logic [QUO_W-1:0]  qb_q    [QUO_W+1];
  logic [DEN_W-1:0]  den_q   [QUO_W+1];
  logic [SIDE_W-1:0] side_q  [QUO_W+1];
  logic [QUO_W:0]    ovf_q;

  logic [RW-1:0] lim;
  logic          ovf_d;

  // Stage 0: flag quotients that do not fit
  assign lim   = RW'(den_i) << QUO_W;
  assign ovf_d = (RW'(num_a_i) >= lim) || (RW'(num_b_i) >= lim);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en_i) begin
      v_q <= {v_q[QUO_W-1:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_a_q[0] <= RW'(num_a_i);
      rem_b_q[0] <= RW'(num_b_i);
      qa_q[0]    <= '0;
      qb_q[0]    <= '0;
      den_q[0]   <= den_i;
      side_q[0]  <= side_i;
      ovf_q[0]   <= ovf_d;
    end
  end

  for (genvar gk = 1; gk <= QUO_W; gk++) begin : g_stage
    localparam int unsigned BIT = QUO_W - gk;

    logic [RW-1:0]    dsh;
    logic             ge_a, ge_b;
    logic [RW-1:0]    rem_a_d, rem_b_d;
    logic [QUO_W-1:0] qa_d, qb_d;

    assign dsh     = RW'(den_q[gk-1]) << BIT;
    assign ge_a    = rem_a_q[gk-1] >= dsh;
    assign ge_b    = rem_b_q[gk-1] >= dsh;
    assign rem_a_d = ge_a ? rem_a_q[gk-1] - dsh : rem_a_q[gk-1];
    assign rem_b_d = ge_b ? rem_b_q[gk-1] - dsh : rem_b_q[gk-1];
    assign qa_d    = qa_q[gk-1] | (QUO_W'(ge_a) << BIT);
    assign qb_d    = qb_q[gk-1] | (QUO_W'(ge_b) << BIT);

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_a_q[gk] <= rem_a_d;
        rem_b_q[gk] <= rem_b_d;
        qa_q[gk]    <= qa_d;
        qb_q[gk]    <= qb_d;
        den_q[gk]   <= den_q[gk-1];
        side_q[gk]  <= side_q[gk-1];
        ovf_q[gk]   <= ovf_q[gk-1];
      end
    end
  end

  assign valid_o = v_q[QUO_W];
  assign ovf_o   = ovf_q[QUO_W];
  assign quo_a_o = qa_q[QUO_W];
  assign quo_b_o = qb_q[QUO_W];
  assign side_o  = side_q[QUO_W];

endmodule

// ===== rtl/active_differential_torque_split_top.sv =====
// Pipeline: tangent stages, speed-sum stages, the two dividers in lockstep, then
//   the output register.
// Throughput: one request per cycle; the whole pipeline advances together and
//   holds while the output register is full and not taken.
// Reset: rst_ni asynchronous, clears every stage valid bit and loads the
//   registers with their reset values; no memory clearing is needed.
// ----------------------------------------------------------------------------
// active_differential_torque_split_top
// Per-request torque split between two motors from steering angle, power
// limit and motor speeds, with a common cap on the larger share.
// ----------------------------------------------------------------------------
module active_differential_torque_split_top #(
  parameter int unsigned TAN_TABLE_ENTRIES = 256
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Request stream
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  // [14:0] steer_angle, [25:15] power_limit, [41:26] left_speed,
  // [57:42] right_speed, [63:58] zero
  input  logic [63:0] s_axis_tdata_i,
  // Result stream
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // [15:0] left_torque, [31:16] right_torque
  output logic [31:0] m_axis_tdata_o,
  // [0] cap_applied, [1] speed_sum_bad
  output logic [1:0]  m_axis_tuser_o,
  // Register port
  input  logic        psel_i,
  input  logic        penable_i,
  input  logic        pwrite_i,
  input  logic [3:0]  paddr_i,
  input  logic [31:0] pwdata_i,
  output logic [31:0] prdata_o,
  output logic        pready_o
);

  localparam int unsigned QW = adts_pkg::QUO_W;
  localparam int unsigned TQ = adts_pkg::TORQUE_W;

  // --------------------------------------------------------------------------
  // Registers
  // --------------------------------------------------------------------------
  logic [adts_pkg::HTW_W-1:0] htw_q;
  logic [adts_pkg::PF_W-1:0]  pf_q;
  logic [adts_pkg::CAP_W-1:0] cap_q;
  logic [adts_pkg::EPS_W-1:0] eps_q;
  logic                       wr_en;
  adts_pkg::reg_idx_e         reg_idx;
  adts_pkg::cfg_t             cfg;

  assign pready_o = 1'b1;
  assign wr_en    = psel_i && penable_i && pwrite_i && pready_o;
  assign reg_idx  = adts_pkg::reg_idx_e'(paddr_i[3:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      htw_q <= adts_pkg::HTW_RST;
      pf_q  <= adts_pkg::PF_RST;
      cap_q <= adts_pkg::CAP_RST;
      eps_q <= adts_pkg::EPS_RST;
    end else if (wr_en) begin
      case (reg_idx)
        adts_pkg::REG_HTW: htw_q <= pwdata_i[adts_pkg::HTW_W-1:0];
        adts_pkg::REG_PF:  pf_q  <= pwdata_i[adts_pkg::PF_W-1:0];
        adts_pkg::REG_CAP: cap_q <= pwdata_i[adts_pkg::CAP_W-1:0];
        adts_pkg::REG_EPS: eps_q <= pwdata_i[adts_pkg::EPS_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      adts_pkg::REG_HTW: prdata_o = 32'(htw_q);
      adts_pkg::REG_PF:  prdata_o = 32'(pf_q);
      adts_pkg::REG_CAP: prdata_o = 32'(cap_q);
      adts_pkg::REG_EPS: prdata_o = 32'(eps_q);
      default:           prdata_o = '0;
    endcase
  end

  assign cfg.power_factor  = pf_q;
  assign cfg.torque_cap    = cap_q;
  assign cfg.speed_epsilon = eps_q;

  // --------------------------------------------------------------------------
  // Pipeline advance: move everything whenever the output register is free
  // or being emptied, so a request can enter every cycle.
  // --------------------------------------------------------------------------
  logic out_valid_q;
  logic adv;

  assign adv             = !out_valid_q || m_axis_tready_i;
  assign s_axis_tready_o = adv;

  // Unpack the request
  adts_pkg::req_side_t in_side;
  assign in_side.power       = s_axis_tdata_i[25:15];
  assign in_side.left_speed  = s_axis_tdata_i[41:26];
  assign in_side.right_speed = s_axis_tdata_i[57:42];

  // --------------------------------------------------------------------------
  // Tangent and coefficients
  // --------------------------------------------------------------------------
  logic                        tan_valid;
  logic [adts_pkg::COEF_W-1:0] tan_cl, tan_cr;
  adts_pkg::req_side_t         tan_side;

  adts_tan #(
    .TAN_TABLE_ENTRIES(TAN_TABLE_ENTRIES)
  ) u_tan (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (adv),
    .valid_i (s_axis_tvalid_i),
    .angle_i (s_axis_tdata_i[14:0]),
    .side_i  (in_side),
    .htw_i   (htw_q),
    .valid_o (tan_valid),
    .cl_o    (tan_cl),
    .cr_o    (tan_cr),
    .side_o  (tan_side)
  );

  // --------------------------------------------------------------------------
  // Speed sum and division operands
  // --------------------------------------------------------------------------
  logic                        den_valid, den_bad;
  logic [adts_pkg::TNUM_W-1:0] den_numl, den_numr;
  logic [adts_pkg::TDEN_W-1:0] den_den;
  logic [adts_pkg::CNUM_W-1:0] den_capl, den_capr;
  logic [adts_pkg::COEF_W-1:0] den_cmax;

  adts_den u_den (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (adv),
    .valid_i (tan_valid),
    .cl_i    (tan_cl),
    .cr_i    (tan_cr),
    .side_i  (tan_side),
    .cfg_i   (cfg),
    .valid_o (den_valid),
    .bad_o   (den_bad),
    .numl_o  (den_numl),
    .numr_o  (den_numr),
    .den_o   (den_den),
    .capl_o  (den_capl),
    .capr_o  (den_capr),
    .cmax_o  (den_cmax)
  );

  // --------------------------------------------------------------------------
  // Two dividers in lockstep: raw shares and capped shares
  // --------------------------------------------------------------------------
  logic          sh_valid, sh_ovf, sh_bad;
  logic [QW-1:0] sh_l, sh_r;
  logic          cp_valid, cp_ovf, cp_bad;
  logic [QW-1:0] cp_l, cp_r;

  adts_div #(
    .NUM_W  (adts_pkg::TNUM_W),
    .DEN_W  (adts_pkg::TDEN_W),
    .QUO_W  (QW),
    .SIDE_W (1)
  ) u_div_share (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (adv),
    .valid_i (den_valid),
    .num_a_i (den_numl),
    .num_b_i (den_numr),
    .den_i   (den_den),
    .side_i  (den_bad),
    .valid_o (sh_valid),
    .ovf_o   (sh_ovf),
    .quo_a_o (sh_l),
    .quo_b_o (sh_r),
    .side_o  (sh_bad)
  );

  adts_div #(
    .NUM_W  (adts_pkg::CNUM_W),
    .DEN_W  (adts_pkg::COEF_W),
    .QUO_W  (QW),
    .SIDE_W (1)
  ) u_div_cap (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (adv),
    .valid_i (den_valid),
    .num_a_i (den_capl),
    .num_b_i (den_capr),
    .den_i   (den_cmax),
    .side_i  (den_bad),
    .valid_o (cp_valid),
    .ovf_o   (cp_ovf),
    .quo_a_o (cp_l),
    .quo_b_o (cp_r),
    .side_o  (cp_bad)
  );

  // --------------------------------------------------------------------------
  // Cap decision and output register. A share quotient that does not fit in
  // 15 bits is above any cap, so it forces the capped pair.
  // --------------------------------------------------------------------------
  logic [QW-1:0] sh_max;
  logic          capped;
  logic [TQ-1:0] lt_d, rt_d, lt_q, rt_q;
  logic          cap_d, bad_d, cap_hit_q, bad_q;

  assign sh_max = (sh_l > sh_r) ? sh_l : sh_r;
  assign capped = sh_ovf || (sh_max > cap_q);

  always_comb begin
    if (sh_bad) begin
      lt_d  = '0;
      rt_d  = '0;
      cap_d = 1'b0;
      bad_d = 1'b1;
    end else begin
      lt_d  = TQ'(capped ? cp_l : sh_l);
      rt_d  = TQ'(capped ? cp_r : sh_r);
      cap_d = capped;
      bad_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= sh_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && sh_valid) begin
      lt_q      <= lt_d;
      rt_q      <= rt_d;
      cap_hit_q <= cap_d;
      bad_q     <= bad_d;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {rt_q, lt_q};
  assign m_axis_tuser_o  = {bad_q, cap_hit_q};

`ifndef SYNTHESIS
  // Both dividers carry the same requests in the same stages
  a_div_lockstep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (sh_valid == cp_valid) && (!sh_valid || (sh_bad == cp_bad)))
    else $error("divider lanes out of step");

  // Capped shares always fit the quotient width
  a_cap_fits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cp_valid && !cp_bad |-> !cp_ovf)
    else $error("capped share quotient overflow");

  // A bad speed sum yields zero torques and no cap flag
  a_bad_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tuser_o[1] |->
      (m_axis_tdata_o == '0) && !m_axis_tuser_o[0])
    else $error("bad speed sum with nonzero result");

  // Neither delivered share exceeds the cap
  a_within_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tuser_o[1] |->
      (lt_q <= TQ'(cap_q)) && (rt_q <= TQ'(cap_q)))
    else $error("share above torque cap");
`endif

endmodule
